// File: src/ittf_pkg.sv
// Shared types, field layout and character constants for the integer-to-text formatter.
// No dependencies; used by every module of the block.
`default_nettype none

package ittf_pkg;

	// Input transfer layout, lowest bit first
	localparam int VALUE_W    = 32;
	localparam int BASE_W     = 6;
	localparam int WIDTH_W    = 7;
	localparam int PREC_W     = 7;
	localparam int FLAGS_W    = 7;
	localparam int VALUE_LSB  = 0;
	localparam int BASE_LSB   = VALUE_LSB + VALUE_W;
	localparam int WIDTH_LSB  = BASE_LSB + BASE_W;
	localparam int PREC_LSB   = WIDTH_LSB + WIDTH_W;
	localparam int FLAGS_LSB  = PREC_LSB + PREC_W;
	localparam int S_TDATA_W  = ((FLAGS_LSB + FLAGS_W + 7) / 8) * 8;

	localparam int CHAR_W     = 8;
	localparam int DIGIT_W    = 6;

	// format_flags bit positions
	localparam int FL_ZERO    = 0;
	localparam int FL_SIGNED  = 1;
	localparam int FL_PLUS    = 2;
	localparam int FL_SPACE   = 3;
	localparam int FL_LEFT    = 4;
	localparam int FL_PREFIX  = 5;
	localparam int FL_LOWER   = 6;

	localparam logic [BASE_W-1:0] BASE_MIN = 6'd2;
	localparam logic [BASE_W-1:0] BASE_MAX = 6'd36;
	localparam logic [BASE_W-1:0] BASE_OCT = 6'd8;
	localparam logic [BASE_W-1:0] BASE_HEX = 6'd16;

	localparam logic [CHAR_W-1:0] CH_NUL   = 8'h00;
	localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;
	localparam logic [CHAR_W-1:0] CH_PLUS  = 8'h2B;
	localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2D;
	localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;
	localparam logic [CHAR_W-1:0] CH_UP_A  = 8'h41;
	localparam logic [CHAR_W-1:0] CH_LO_A  = 8'h61;
	localparam logic [CHAR_W-1:0] CH_UP_X  = 8'h58;
	localparam logic [CHAR_W-1:0] CH_LO_X  = 8'h78;

	// Status from the digit generator to the sequencer
	typedef struct packed {
		logic               push;
		logic [DIGIT_W-1:0] digit;
		logic               done;
	} gen_stat_t;

	// Digit value 0..35 to its ASCII character
	function automatic logic [CHAR_W-1:0] digit_char(input logic [DIGIT_W-1:0] d,
		input logic lower);
		logic [CHAR_W-1:0] dx;
		dx = {{(CHAR_W-DIGIT_W){1'b0}}, d};
		if (d < 6'd10) begin
			digit_char = CH_ZERO + dx;
		end else begin
			digit_char = (lower ? CH_LO_A : CH_UP_A) + dx - 8'd10;
		end
	endfunction

endpackage

`default_nettype wire

// File: src/integer_to_text_formatter.sv
// Integer-to-text formatter, printf-style integer conversion, one character per transfer.
// Depends on ittf_pkg, ittf_digit_gen and ittf_stack.
//
// Input channel s_*: one transfer carries one number with base, width, precision and flags.
// Output channel m_*: one transfer per text character; m_tlast marks the final character
// of a number, m_tuser flags a base outside 2..36 (one transfer, character 0, tlast set).
// Timing: after a number is taken, a bit-serial divider produces its digits one by one;
// once division closes, the sequencer plans the text in ST_PLAN, then emits one character
// per cycle while m_tready is high. A new input transfer is taken only after the final
// character of the previous number has been loaded into the output register. A bad base
// goes straight to ST_BAD, which loads the single error transfer.
// Text is clipped to MAX_CHARS characters, digits to MAX_DIGITS (low digits kept).
// s_tready is high whenever the block is between numbers, even while the final
// character still sits in the output register waiting for m_tready.
// A stalled receiver simply holds the output register; text generation pauses.
// Reset (arst_n low) clears m_tvalid and returns the sequencer to idle, so s_tready
// reads high; the source must offer no input while reset is held, which the block does not enforce.
`default_nettype none

module integer_to_text_formatter #(
	parameter int VALUE_BITS = 32,
	parameter int MAX_DIGITS = 32,
	parameter int MAX_CHARS  = 64
) (
	input  wire                                 clk,
	input  wire                                 arst_n,
	input  wire                                 s_tvalid,
	output logic                                s_tready,
	// value[31:0], base[37:32], width[44:38], precision[51:45], format_flags[58:52], zero fill
	input  wire [ittf_pkg::S_TDATA_W-1:0]       s_tdata,
	output logic                                m_tvalid,
	input  wire                                 m_tready,
	// character[7:0]
	output logic [ittf_pkg::CHAR_W-1:0]         m_tdata,
	output logic                                m_tlast,
	// bad_base
	output logic                                m_tuser
);

	localparam int NDW = $clog2(MAX_DIGITS + 1);
	localparam int SW  = $clog2(MAX_DIGITS + MAX_CHARS + 256) + 1;
	localparam int CW  = $clog2(MAX_CHARS + 1);

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_DIV  = 3'd1;
	localparam logic [2:0] ST_PLAN = 3'd2;
	localparam logic [2:0] ST_EMIT = 3'd3;
	localparam logic [2:0] ST_BAD  = 3'd4;

	localparam logic [2:0] SEG_PADL = 3'd0;
	localparam logic [2:0] SEG_SIGN = 3'd1;
	localparam logic [2:0] SEG_PFX0 = 3'd2;
	localparam logic [2:0] SEG_PFXX = 3'd3;
	localparam logic [2:0] SEG_ZPAD = 3'd4;
	localparam logic [2:0] SEG_PREC = 3'd5;
	localparam logic [2:0] SEG_DIG  = 3'd6;
	localparam logic [2:0] SEG_PADR = 3'd7;

	// field decode
	logic [ittf_pkg::VALUE_W-1:0]        s_value;
	logic [ittf_pkg::BASE_W-1:0]         s_base;
	logic signed [ittf_pkg::WIDTH_W-1:0] s_width;
	logic signed [ittf_pkg::PREC_W-1:0]  s_prec;
	logic [ittf_pkg::FLAGS_W-1:0]        s_flags;

	assign s_value = s_tdata[ittf_pkg::VALUE_LSB +: ittf_pkg::VALUE_W];
	assign s_base  = s_tdata[ittf_pkg::BASE_LSB  +: ittf_pkg::BASE_W];
	assign s_width = s_tdata[ittf_pkg::WIDTH_LSB +: ittf_pkg::WIDTH_W];
	assign s_prec  = s_tdata[ittf_pkg::PREC_LSB  +: ittf_pkg::PREC_W];
	assign s_flags = s_tdata[ittf_pkg::FLAGS_LSB +: ittf_pkg::FLAGS_W];

	logic [2:0] st_q;
	logic       accept;
	logic       base_ok;

	assign s_tready = st_q == ST_IDLE;
	assign accept   = s_tvalid && s_tready;
	assign base_ok  = (s_base >= ittf_pkg::BASE_MIN) && (s_base <= ittf_pkg::BASE_MAX);

	// value bits above VALUE_BITS are dropped, missing ones are zero
	logic [VALUE_BITS+ittf_pkg::VALUE_W-1:0] val_wide;
	logic [VALUE_BITS-1:0]                   val_v;
	logic                                    neg;
	logic [VALUE_BITS-1:0]                   mag;

	assign val_wide = {{VALUE_BITS{1'b0}}, s_value};
	assign val_v    = val_wide[VALUE_BITS-1:0];
	assign neg      = s_flags[ittf_pkg::FL_SIGNED] && val_v[VALUE_BITS-1];
	assign mag      = neg ? (~val_v + 1'b1) : val_v;

	// digit generation and reversal
	ittf_pkg::gen_stat_t          gen_stat;
	logic [NDW-1:0]               gen_nd;
	logic [ittf_pkg::DIGIT_W-1:0] tos;
	logic                         pop;

	ittf_digit_gen #(
		.VALUE_BITS (VALUE_BITS),
		.MAX_DIGITS (MAX_DIGITS),
		.NDW        (NDW)
	) u_gen (
		.clk    (clk),
		.arst_n (arst_n),
		.load   (accept && base_ok),
		.mag    (mag),
		.base   (s_base),
		.stat   (gen_stat),
		.nd     (gen_nd)
	);

	ittf_stack #(
		.DEPTH (MAX_DIGITS)
	) u_stack (
		.clk  (clk),
		.push (gen_stat.push),
		.pop  (pop),
		.din  (gen_stat.digit),
		.tos  (tos)
	);

	// per-item settings captured at accept
	logic signed [ittf_pkg::WIDTH_W-1:0] width_q;
	logic signed [ittf_pkg::PREC_W-1:0]  prec_q;
	logic                                zero_q;
	logic                                left_q;
	logic                                lower_q;
	logic                                sign_q;
	logic [ittf_pkg::CHAR_W-1:0]         sign_ch_q;
	logic                                pfx0_q;
	logic                                pfxx_q;

	// segment counters for the text
	logic [SW-1:0]  padl_q;
	logic [SW-1:0]  zpad_q;
	logic [SW-1:0]  padr_q;
	logic [SW-1:0]  przero_q;
	logic [NDW-1:0] dig_q;
	logic [CW-1:0]  rem_q;

	// plan arithmetic, all signed
	logic signed [SW-1:0] nd_s;
	logic signed [SW-1:0] prec_s;
	logic signed [SW-1:0] prec_eff;
	logic signed [SW-1:0] fixed_n;
	logic signed [SW-1:0] size_s;
	logic signed [SW-1:0] pad_s;
	logic signed [SW-1:0] total_s;

	always_comb begin
		nd_s     = SW'({1'b0, gen_nd});
		prec_s   = SW'(prec_q);
		prec_eff = (prec_s > nd_s) ? prec_s : nd_s;
		fixed_n  = SW'({1'b0, sign_q}) + SW'({1'b0, pfx0_q}) + SW'({1'b0, pfxx_q});
		size_s   = SW'(width_q) - fixed_n - prec_eff;
		pad_s    = (size_s > 0) ? size_s : '0;
		total_s  = pad_s + fixed_n + prec_eff;
	end

	// emission: first nonempty segment supplies the character
	logic                        out_free;
	logic                        emit;
	logic                        out_load;
	logic [2:0]                  seg;
	logic [ittf_pkg::CHAR_W-1:0] emit_ch;

	assign out_free = !m_tvalid || m_tready;
	assign emit     = (st_q == ST_EMIT) && out_free;
	assign out_load = emit || ((st_q == ST_BAD) && out_free);
	assign pop      = emit && (seg == SEG_DIG);

	always_comb begin
		priority if (padl_q != '0) begin
			seg = SEG_PADL;
		end else if (sign_q) begin
			seg = SEG_SIGN;
		end else if (pfx0_q) begin
			seg = SEG_PFX0;
		end else if (pfxx_q) begin
			seg = SEG_PFXX;
		end else if (zpad_q != '0) begin
			seg = SEG_ZPAD;
		end else if (przero_q != '0) begin
			seg = SEG_PREC;
		end else if (dig_q != '0) begin
			seg = SEG_DIG;
		end else begin
			seg = SEG_PADR;
		end
	end

	always_comb begin
		unique case (seg)
			SEG_PADL: emit_ch = ittf_pkg::CH_SPACE;
			SEG_SIGN: emit_ch = sign_ch_q;
			SEG_PFX0: emit_ch = ittf_pkg::CH_ZERO;
			SEG_PFXX: emit_ch = lower_q ? ittf_pkg::CH_LO_X : ittf_pkg::CH_UP_X;
			SEG_ZPAD: emit_ch = ittf_pkg::CH_ZERO;
			SEG_PREC: emit_ch = ittf_pkg::CH_ZERO;
			SEG_DIG:  emit_ch = ittf_pkg::digit_char(tos, lower_q);
			default:  emit_ch = ittf_pkg::CH_SPACE;
		endcase
	end

	// sequencer and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q     <= ST_IDLE;
			m_tvalid <= 1'b0;
		end else begin
			if (out_load) begin
				m_tvalid <= 1'b1;
			end else if (m_tready) begin
				m_tvalid <= 1'b0;
			end
			unique case (st_q)
				ST_IDLE: begin
					if (accept) begin
						st_q <= base_ok ? ST_DIV : ST_BAD;
					end
				end
				ST_DIV: begin
					if (gen_stat.done) begin
						st_q <= ST_PLAN;
					end
				end
				ST_PLAN: begin
					st_q <= ST_EMIT;
				end
				ST_EMIT: begin
					if (emit && (rem_q == CW'(1))) begin
						st_q <= ST_IDLE;
					end
				end
				ST_BAD: begin
					if (out_free) begin
						st_q <= ST_IDLE;
					end
				end
				default: begin
					st_q <= ST_IDLE;
				end
			endcase
		end
	end

	// item settings, counters and output payload
	always_ff @(posedge clk) begin
		if (accept) begin
			width_q <= s_width;
			prec_q  <= s_prec;
			left_q  <= s_flags[ittf_pkg::FL_LEFT];
			zero_q  <= s_flags[ittf_pkg::FL_ZERO] && !s_flags[ittf_pkg::FL_LEFT];
			lower_q <= s_flags[ittf_pkg::FL_LOWER];
			sign_q  <= neg || s_flags[ittf_pkg::FL_PLUS] || s_flags[ittf_pkg::FL_SPACE];
			priority if (neg) begin
				sign_ch_q <= ittf_pkg::CH_MINUS;
			end else if (s_flags[ittf_pkg::FL_PLUS]) begin
				sign_ch_q <= ittf_pkg::CH_PLUS;
			end else begin
				sign_ch_q <= ittf_pkg::CH_SPACE;
			end
			pfx0_q <= s_flags[ittf_pkg::FL_PREFIX] &&
				((s_base == ittf_pkg::BASE_OCT) || (s_base == ittf_pkg::BASE_HEX));
			pfxx_q <= s_flags[ittf_pkg::FL_PREFIX] && (s_base == ittf_pkg::BASE_HEX);
		end

		if (st_q == ST_PLAN) begin
			padl_q   <= (!zero_q && !left_q) ? pad_s : '0;
			zpad_q   <= zero_q ? pad_s : '0;
			padr_q   <= left_q ? pad_s : '0;
			przero_q <= prec_eff - nd_s;
			dig_q    <= gen_nd;
			rem_q    <= (total_s > SW'(MAX_CHARS)) ? CW'(MAX_CHARS) : total_s[CW-1:0];
		end

		if (emit) begin
			rem_q   <= rem_q - 1'b1;
			m_tdata <= emit_ch;
			m_tlast <= rem_q == CW'(1);
			m_tuser <= 1'b0;
			unique case (seg)
				SEG_PADL: padl_q   <= padl_q - 1'b1;
				SEG_SIGN: sign_q   <= 1'b0;
				SEG_PFX0: pfx0_q   <= 1'b0;
				SEG_PFXX: pfxx_q   <= 1'b0;
				SEG_ZPAD: zpad_q   <= zpad_q - 1'b1;
				SEG_PREC: przero_q <= przero_q - 1'b1;
				SEG_DIG:  dig_q    <= dig_q - 1'b1;
				default:  padr_q   <= padr_q - 1'b1;
			endcase
		end else if ((st_q == ST_BAD) && out_free) begin
			m_tdata <= ittf_pkg::CH_NUL;
			m_tlast <= 1'b1;
			m_tuser <= 1'b1;
		end
	end

endmodule

`default_nettype wire

// File: src/ittf_digit_gen.sv
// Bit-serial restoring divider that peels base digits off a magnitude, low digit first.
// Depends on ittf_pkg for the digit width and the status struct.
`default_nettype none

module ittf_digit_gen #(
	parameter int VALUE_BITS = 32,
	parameter int MAX_DIGITS = 32,
	parameter int NDW        = $clog2(MAX_DIGITS + 1)
) (
	input  wire                              clk,
	input  wire                              arst_n,
	input  wire                              load,
	input  wire [VALUE_BITS-1:0]             mag,
	input  wire [ittf_pkg::BASE_W-1:0]       base,
	output ittf_pkg::gen_stat_t              stat,
	output logic [NDW-1:0]                   nd
);

	localparam int BW = $clog2(VALUE_BITS);

	logic                          busy_q;
	logic [VALUE_BITS-1:0]         q_q;
	logic [ittf_pkg::DIGIT_W-1:0]  rem_q;
	logic [BW-1:0]                 bit_q;
	logic                          qnz_q;
	logic [NDW-1:0]                nd_q;
	logic [ittf_pkg::BASE_W-1:0]   base_q;
	logic                          push_q;
	logic                          done_q;
	logic [ittf_pkg::DIGIT_W-1:0]  digit_q;

	logic [ittf_pkg::DIGIT_W:0]    trial;
	logic                          ge;
	logic [ittf_pkg::DIGIT_W:0]    diff;
	logic [ittf_pkg::DIGIT_W-1:0]  nrem;
	logic [NDW-1:0]                nd_inc;
	logic                          last_bit;
	logic                          next_digit;
	logic                          digit_end;

	assign trial      = {rem_q, q_q[VALUE_BITS-1]};
	assign ge         = trial >= {1'b0, base_q};
	assign diff       = trial - {1'b0, base_q};
	assign nrem       = ge ? diff[ittf_pkg::DIGIT_W-1:0] : trial[ittf_pkg::DIGIT_W-1:0];
	assign nd_inc     = nd_q + 1'b1;
	assign last_bit   = bit_q == BW'(VALUE_BITS - 1);
	// another digit follows while the quotient is nonzero and the digit limit allows
	assign next_digit = (qnz_q || ge) && (nd_inc < NDW'(MAX_DIGITS));
	assign digit_end  = busy_q && !load && last_bit;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			push_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			push_q <= digit_end;
			done_q <= digit_end && !next_digit;
			if (load) begin
				busy_q <= 1'b1;
			end else if (digit_end && !next_digit) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			q_q    <= mag;
			base_q <= base;
			rem_q  <= '0;
			bit_q  <= '0;
			qnz_q  <= 1'b0;
			nd_q   <= '0;
		end else if (busy_q) begin
			q_q <= {q_q[VALUE_BITS-2:0], ge};
			if (last_bit) begin
				// quotient complete: next digit restarts on it
				rem_q   <= '0;
				bit_q   <= '0;
				qnz_q   <= 1'b0;
				nd_q    <= nd_inc;
				digit_q <= nrem;
			end else begin
				qnz_q <= qnz_q | ge;
				rem_q <= nrem;
				bit_q <= bit_q + 1'b1;
			end
		end
	end

	assign stat.push  = push_q;
	assign stat.digit = digit_q;
	assign stat.done  = done_q;
	assign nd         = nd_q;

endmodule

`default_nettype wire

// File: src/ittf_stack.sv
// Shift-register LIFO that reverses the digit order: pushed low digit first, popped high first.
// Depends on ittf_pkg for the digit width.
`default_nettype none

module ittf_stack #(
	parameter int DEPTH = 32
) (
	input  wire                              clk,
	input  wire                              push,
	input  wire                              pop,
	input  wire [ittf_pkg::DIGIT_W-1:0]      din,
	output logic [ittf_pkg::DIGIT_W-1:0]     tos
);

	logic [ittf_pkg::DIGIT_W-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[0] <= din;
			for (int i = 1; i < DEPTH; i++) begin
				mem_q[i] <= mem_q[i-1];
			end
		end else if (pop) begin
			for (int i = 0; i < DEPTH - 1; i++) begin
				mem_q[i] <= mem_q[i+1];
			end
		end
	end

	assign tos = mem_q[0];

endmodule

`default_nettype wire
